// File: hw/rtl/interval_list_intersection_unit_defines.svh
// assertion macros for the interval list intersection unit
// included by the checker; no other dependencies
`ifndef INTERVAL_LIST_INTERSECTION_UNIT_DEFINES_SVH
`define INTERVAL_LIST_INTERSECTION_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ILU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ILU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ilu_pkg.sv
// shared constants, types and codes of the interval list intersection unit
// no dependencies
`timescale 1ns / 1ps

package ilu_pkg;

  localparam int unsigned MAX_INTERVALS = 32;
  localparam int unsigned TIME_BITS     = 16;
  localparam int unsigned MAX_RESULTS   = 64;

  // packed interval key: start in the upper half, end in the lower half
  localparam int unsigned KEY_W  = 2 * TIME_BITS;
  localparam int unsigned DATA_W = ((KEY_W + 7) / 8) * 8;

  localparam int unsigned IDX_W  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned RIDX_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int unsigned RCNT_W = $clog2(MAX_RESULTS + 1);

  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned USER_W        = 2;
  localparam int unsigned USER_NONE_BIT = 0;
  localparam int unsigned USER_OVF_BIT  = 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_RUN    = 2'd2
  } func_e;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [KEY_W-1:0]     key_t;

endpackage

// File: hw/rtl/ilu_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ilu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/interval_list_intersection_unit.sv
// top level of the interval list intersection unit
// depends on ilu_pkg and ilu_ram
`timescale 1ns / 1ps

// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/tready         tdata: start_time, end_time; tuser: func
// m_axis    out  m_axis_tvalid/tready         tdata: out_start, out_end; tlast: last;
//                                             tuser: none_found, overflow
//
// a load transaction leaves the input ready after it
// a run walks every a/b pair through one shared overlap and compare path:
//   a list ram read and then an overlap check per pair, and for each hit a
//   sorted insertion into the result ram, a read and a compare per entry it passes
// each result then leaves by a ram read, a load and a present step, plus
//   any output stall; the input is not ready from run accept to final tlast
// reset clears the counts and the state machine; list and result rams
//   are not cleared, only entries below the counts are ever read

module interval_list_intersection_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [15:0] start_time, [31:16] end_time
  input  logic [ilu_pkg::DATA_W-1:0]   s_axis_tdata_i,
  // [1:0] func
  input  logic [ilu_pkg::FUNC_W-1:0]   s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [15:0] out_start, [31:16] out_end
  output logic [ilu_pkg::DATA_W-1:0]   m_axis_tdata_o,
  output logic                         m_axis_tlast_o,
  // [0] none_found, [1] overflow
  output logic [ilu_pkg::USER_W-1:0]   m_axis_tuser_o
);

  import ilu_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_FETCH   = 8'b0000_0010,
    S_EVAL    = 8'b0000_0100,
    S_INS_RD  = 8'b0000_1000,
    S_INS_CMP = 8'b0001_0000,
    S_OUT_RD  = 8'b0010_0000,
    S_OUT_LD  = 8'b0100_0000,
    S_OUT     = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic hit;
    key_t key;
  } pair_t;

  // overlap of one a/b pair, first matching rule wins
  function automatic pair_t pair_rule(key_t a, key_t b);
    time_t as, ae, bs, be;
    pair_t r;
    as = a[KEY_W-1:TIME_BITS];
    ae = a[TIME_BITS-1:0];
    bs = b[KEY_W-1:TIME_BITS];
    be = b[TIME_BITS-1:0];
    r.hit = 1'b1;
    r.key = a;
    priority if (as >= bs && ae <= be) begin
      r.key = a;                        // a contained in b
    end else if (as <= bs && ae >= be) begin
      r.key = b;                        // b contained in a
    end else if (as <= bs && ae <= be && ae > bs) begin
      r.key = {bs, ae};                 // a hangs over the left of b
    end else if (as >= bs && ae >= be && as < be) begin
      r.key = {as, be};                 // a hangs over the right of b
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic               ovf_seen_q, ovf_seen_d;
  logic               run_ovf_q, run_ovf_d;
  logic [IDX_W-1:0]   i_q, i_d, j_q, j_d;
  key_t               carry_q, carry_d;
  logic [RCNT_W-1:0]  pos_q, pos_d;
  logic [RCNT_W-1:0]  res_cnt_q, res_cnt_d;
  logic [RIDX_W-1:0]  k_q, k_d;
  key_t               out_key_q, out_key_d;
  logic               out_none_q, out_none_d;
  logic               out_last_q, out_last_d;

  // input fields
  time_t in_start, in_end;
  key_t  in_key;
  func_e in_func;
  logic  in_acc;

  assign in_start = s_axis_tdata_i[TIME_BITS-1:0];
  assign in_end   = s_axis_tdata_i[KEY_W-1:TIME_BITS];
  assign in_key   = {in_start, in_end};
  assign in_func  = func_e'(s_axis_tuser_i);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  // list rams
  logic full_a, full_b, we_a, we_b;
  key_t rdata_a, rdata_b;

  assign full_a = (cnt_a_q == CNT_W'(MAX_INTERVALS));
  assign full_b = (cnt_b_q == CNT_W'(MAX_INTERVALS));
  assign we_a   = in_acc && (in_func == FUNC_LOAD_A) && !full_a;
  assign we_b   = in_acc && (in_func == FUNC_LOAD_B) && !full_b;

  ilu_ram #(.WIDTH(KEY_W), .DEPTH(MAX_INTERVALS)) u_list_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[IDX_W-1:0]),
    .wdata_i (in_key),
    .raddr_i (i_q),
    .rdata_o (rdata_a)
  );

  ilu_ram #(.WIDTH(KEY_W), .DEPTH(MAX_INTERVALS)) u_list_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[IDX_W-1:0]),
    .wdata_i (in_key),
    .raddr_i (j_q),
    .rdata_o (rdata_b)
  );

  // result ram, kept sorted and distinct
  logic              we_r;
  logic [RIDX_W-1:0] raddr_r;
  key_t              rdata_r;

  assign raddr_r = (state_q == S_OUT_RD) ? k_q : pos_q[RIDX_W-1:0];

  ilu_ram #(.WIDTH(KEY_W), .DEPTH(MAX_RESULTS)) u_results (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (pos_q[RIDX_W-1:0]),
    .wdata_i (carry_q),
    .raddr_i (raddr_r),
    .rdata_o (rdata_r)
  );

  // pair loop bookkeeping; an empty list counts as a loop of one
  logic [CNT_W-1:0] lim_a_m1, lim_b_m1;
  logic             last_i, last_j, loop_done;
  logic [IDX_W-1:0] i_next, j_next;
  pair_t            cand;

  assign lim_a_m1  = (cnt_a_q == '0) ? '0 : cnt_a_q - CNT_W'(1);
  assign lim_b_m1  = (cnt_b_q == '0) ? '0 : cnt_b_q - CNT_W'(1);
  assign last_i    = (CNT_W'(i_q) == lim_a_m1);
  assign last_j    = (CNT_W'(j_q) == lim_b_m1);
  assign loop_done = last_i && last_j;
  assign i_next    = last_i ? '0 : i_q + IDX_W'(1);
  assign j_next    = last_i ? j_q + IDX_W'(1) : j_q;

  // one list empty: the other passes through the insertion unchanged
  always_comb begin
    if (cnt_b_q == '0) begin
      cand = '{hit: 1'b1, key: rdata_a};
    end else if (cnt_a_q == '0) begin
      cand = '{hit: 1'b1, key: rdata_b};
    end else begin
      cand = pair_rule(rdata_a, rdata_b);
    end
  end

  logic [RCNT_W-1:0] res_last;
  assign res_last = res_cnt_q - RCNT_W'(1);

  always_comb begin
    state_d    = state_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    ovf_seen_d = ovf_seen_q;
    run_ovf_d  = run_ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    carry_d    = carry_q;
    pos_d      = pos_q;
    res_cnt_d  = res_cnt_q;
    k_d        = k_q;
    out_key_d  = out_key_q;
    out_none_d = out_none_q;
    out_last_d = out_last_q;
    we_r       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_func)
            FUNC_LOAD_A: begin
              if (full_a) ovf_seen_d = 1'b1;
              else cnt_a_d = cnt_a_q + CNT_W'(1);
            end
            FUNC_LOAD_B: begin
              if (full_b) ovf_seen_d = 1'b1;
              else cnt_b_d = cnt_b_q + CNT_W'(1);
            end
            FUNC_RUN: begin
              run_ovf_d  = ovf_seen_q;
              ovf_seen_d = 1'b0;
              i_d        = '0;
              j_d        = '0;
              res_cnt_d  = '0;
              if (cnt_a_q == '0 && cnt_b_q == '0) begin
                out_key_d  = '0;
                out_none_d = 1'b1;
                out_last_d = 1'b1;
                state_d    = S_OUT;
              end else begin
                state_d = S_FETCH;
              end
            end
            default: ;  // unused code, dropped
          endcase
        end
      end

      S_FETCH: state_d = S_EVAL;

      S_EVAL: begin
        if (cand.hit) begin
          carry_d = cand.key;
          pos_d   = '0;
          state_d = S_INS_RD;
        end else begin
          i_d = i_next;
          j_d = j_next;
          if (loop_done) begin
            k_d = '0;
            if (res_cnt_q == '0) begin
              out_key_d  = '0;
              out_none_d = 1'b1;
              out_last_d = 1'b1;
              state_d    = S_OUT;
            end else begin
              state_d = S_OUT_RD;
            end
          end else begin
            state_d = S_FETCH;
          end
        end
      end

      S_INS_RD: begin
        if (pos_q == res_cnt_q) begin
          // end of buffer: append unless full, a full buffer drops the largest
          if (res_cnt_q != RCNT_W'(MAX_RESULTS)) begin
            we_r      = 1'b1;
            res_cnt_d = res_cnt_q + RCNT_W'(1);
          end
          i_d = i_next;
          j_d = j_next;
          k_d = '0;
          state_d = loop_done ? S_OUT_RD : S_FETCH;
        end else begin
          state_d = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        priority if (rdata_r == carry_q) begin
          // duplicate, nothing to insert
          i_d = i_next;
          j_d = j_next;
          k_d = '0;
          state_d = loop_done ? S_OUT_RD : S_FETCH;
        end else if (rdata_r < carry_q) begin
          pos_d   = pos_q + RCNT_W'(1);
          state_d = S_INS_RD;
        end else begin
          // place carry here and move the displaced entry up
          we_r    = 1'b1;
          carry_d = rdata_r;
          pos_d   = pos_q + RCNT_W'(1);
          state_d = S_INS_RD;
        end
      end

      S_OUT_RD: state_d = S_OUT_LD;

      S_OUT_LD: begin
        out_key_d  = rdata_r;
        out_none_d = 1'b0;
        out_last_d = (RCNT_W'(k_q) == res_last);
        state_d    = S_OUT;
      end

      S_OUT: begin
        if (m_axis_tready_i) begin
          if (out_last_q) begin
            cnt_a_d = '0;
            cnt_b_d = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + RIDX_W'(1);
            state_d = S_OUT_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      ovf_seen_q <= 1'b0;
      res_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      ovf_seen_q <= ovf_seen_d;
      res_cnt_q  <= res_cnt_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    run_ovf_q  <= run_ovf_d;
    i_q        <= i_d;
    j_q        <= j_d;
    carry_q    <= carry_d;
    pos_q      <= pos_d;
    k_q        <= k_d;
    out_key_q  <= out_key_d;
    out_none_q <= out_none_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  // out_key holds {start, end}; tdata carries start in the low half
  assign m_axis_tdata_o  = DATA_W'({out_key_q[TIME_BITS-1:0], out_key_q[KEY_W-1:TIME_BITS]});
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    m_axis_tuser_o                = '0;
    m_axis_tuser_o[USER_NONE_BIT] = out_none_q;
    m_axis_tuser_o[USER_OVF_BIT]  = run_ovf_q;
  end

endmodule

// File: hw/rtl/ilu_checker.sv
// port-level checker for the interval list intersection unit, with its bind
// depends on ilu_pkg and interval_list_intersection_unit_defines.svh
`timescale 1ns / 1ps

`include "interval_list_intersection_unit_defines.svh"

module ilu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  // [15:0] start_time, [31:16] end_time
  input logic [ilu_pkg::DATA_W-1:0]   s_axis_tdata_i,
  // [1:0] func
  input logic [ilu_pkg::FUNC_W-1:0]   s_axis_tuser_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  // [15:0] out_start, [31:16] out_end
  input logic [ilu_pkg::DATA_W-1:0]   m_axis_tdata_o,
  input logic                         m_axis_tlast_o,
  // [0] none_found, [1] overflow
  input logic [ilu_pkg::USER_W-1:0]   m_axis_tuser_o
);

  import ilu_pkg::*;

  logic in_acc, out_acc, load_acc;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign load_acc = in_acc && (s_axis_tuser_i == FUNC_LOAD_A || s_axis_tuser_i == FUNC_LOAD_B);

  // stalled result holds
  `ILU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o), "stalled result changed")
  // no new transaction is taken while a run's results are out
  `ILU_ASSERT_SAME(a_busy_out, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o, "input ready during result output")
  // an empty answer is a single zero transaction closing the run
  `ILU_ASSERT_SAME(a_none_form, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[USER_NONE_BIT], m_axis_tlast_o && (m_axis_tdata_o == '0), "malformed empty answer")
  // the final result frees the input
  `ILU_ASSERT_NEXT(a_last_frees, clk_i, rst_ni, out_acc && m_axis_tlast_o, s_axis_tready_o, "input not ready after run")
  // loads never stall the input
  `ILU_ASSERT_NEXT(a_load_ready, clk_i, rst_ni, load_acc, s_axis_tready_o, "input not ready after load")

endmodule

bind interval_list_intersection_unit ilu_checker u_ilu_checker (.*);
